[hw/rtl/world_to_object_frame_defines.svh]
// ----------------------------------------------------------------------------
// World to object frame: assertion macros
// Shared assertion wrappers for the world to object frame pipeline.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_OBJECT_FRAME_DEFINES_SVH
`define WORLD_TO_OBJECT_FRAME_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define W2O_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define W2O_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/w2o_pkg.sv]
// ----------------------------------------------------------------------------
// World to object frame: package
// Widths, constants and stage types shared by the pipeline modules.
// ----------------------------------------------------------------------------
package w2o_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 32;
  localparam int ANGLE_BITS    = 16;

  localparam int CORDIC_N    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int IN_W        = 32;
  localparam int HEAD_W      = 16;
  localparam int DIFF_W      = IN_W + 1;
  localparam int GUARD_BITS  = 8;
  localparam int VEC_W       = DIFF_W + GUARD_BITS + 3;
  localparam int TURN_W      = 32;
  localparam int Z_W         = TURN_W + 2;
  localparam int KINV_W      = 21;
  localparam int ROUND_SHIFT = 28;
  localparam int PROD_W      = VEC_W + KINV_W;
  localparam int OUT_W       = 32;

  localparam logic signed [KINV_W-1:0] KINV = KINV_W'(636751);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [TURN_W-1:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic [HEAD_W-1:0]       rel_heading;
  } w2o_rot_t;

  typedef struct packed {
    logic [OUT_W-1:0]  local_x;
    logic [OUT_W-1:0]  local_y;
    logic [HEAD_W-1:0] relative_heading;
    logic              saturated;
  } w2o_res_t;

endpackage

[hw/rtl/world_to_object_frame.sv]
// ----------------------------------------------------------------------------
// World to object frame
// Expresses a world point in an object's frame: translate, rotate by minus
// the object heading with a pipelined CORDIC, and wrap the relative heading.
//
//   Channel  Dir  Contents
//   s_axis   in   point_x, point_y, point_heading, object_x, object_y,
//                 object_heading
//   m_axis   out  local_x, local_y, relative_heading; saturated in tuser
//
// One request is accepted per cycle while the pipeline advances. A request passes
// through the input register, one register per CORDIC micro-rotation, and the
// multiply and output registers.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears only the valid bits; the pipeline is empty afterward.
// ----------------------------------------------------------------------------
module world_to_object_frame
  import w2o_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x[31:0], point_y[63:32], point_heading[79:64], object_x[111:80],
  // object_y[143:112], object_heading[159:144]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // local_x[31:0], local_y[63:32], relative_heading[79:64]
  output logic [79:0]  m_axis_tdata,
  // saturated[0]
  output logic         m_axis_tuser
);

  logic     adv;
  logic     prep_valid;
  w2o_rot_t prep_rot;
  logic     cordic_valid;
  w2o_rot_t cordic_rot;
  logic     res_valid;
  w2o_res_t res;

  assign adv           = !res_valid || m_axis_tready;
  assign s_axis_tready = adv;

  w2o_prep u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (adv),
    .valid_i          (s_axis_tvalid),
    .point_x_i        (s_axis_tdata[31:0]),
    .point_y_i        (s_axis_tdata[63:32]),
    .point_heading_i  (s_axis_tdata[79:64]),
    .object_x_i       (s_axis_tdata[111:80]),
    .object_y_i       (s_axis_tdata[143:112]),
    .object_heading_i (s_axis_tdata[159:144]),
    .valid_o          (prep_valid),
    .rot_o            (prep_rot)
  );

  w2o_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (prep_valid),
    .rot_i   (prep_rot),
    .valid_o (cordic_valid),
    .rot_o   (cordic_rot)
  );

  w2o_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cordic_valid),
    .rot_i   (cordic_rot),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res.relative_heading, res.local_y, res.local_x};
  assign m_axis_tuser  = res.saturated;

endmodule

[hw/rtl/w2o_prep.sv]
// ----------------------------------------------------------------------------
// World to object frame: input stage
// Forms the offset vector, the rotation angle with quadrant folding and the
// wrapped relative heading, and registers them.
// ----------------------------------------------------------------------------
module w2o_prep
  import w2o_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [IN_W-1:0]    point_x_i,
  input  logic [IN_W-1:0]    point_y_i,
  input  logic [HEAD_W-1:0]  point_heading_i,
  input  logic [IN_W-1:0]    object_x_i,
  input  logic [IN_W-1:0]    object_y_i,
  input  logic [HEAD_W-1:0]  object_heading_i,
  output logic               valid_o,
  output w2o_rot_t           rot_o
);

  logic [DIFF_W-1:0]   dx;
  logic [DIFF_W-1:0]   dy;
  logic [VEC_W-1:0]    x_scaled;
  logic [VEC_W-1:0]    y_scaled;
  logic [TURN_W-1:0]   ph_ext;
  logic [TURN_W-1:0]   oh_ext;
  logic [TURN_W-1:0]   oh_turn;
  logic [TURN_W-1:0]   zu;
  logic                fold;
  logic [ANGLE_BITS-1:0] head_diff;
  logic [TURN_W-1:0]   head_diff_ext;
  w2o_rot_t            rot_d;
  w2o_rot_t            rot_q;
  logic                valid_q;

  always_comb begin
    dx = {point_x_i[IN_W-1], point_x_i} - {object_x_i[IN_W-1], object_x_i};
    dy = {point_y_i[IN_W-1], point_y_i} - {object_y_i[IN_W-1], object_y_i};
    x_scaled = {{(VEC_W - DIFF_W - GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
    y_scaled = {{(VEC_W - DIFF_W - GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};

    ph_ext  = {{(TURN_W - HEAD_W){point_heading_i[HEAD_W-1]}}, point_heading_i};
    oh_ext  = {{(TURN_W - HEAD_W){object_heading_i[HEAD_W-1]}}, object_heading_i};
    oh_turn = {oh_ext[ANGLE_BITS-1:0], {(TURN_W - ANGLE_BITS){1'b0}}};
    zu      = '0 - oh_turn;
    fold    = zu[TURN_W-1] ^ zu[TURN_W-2];

    head_diff     = ph_ext[ANGLE_BITS-1:0] - oh_ext[ANGLE_BITS-1:0];
    head_diff_ext = {{(TURN_W - ANGLE_BITS){head_diff[ANGLE_BITS-1]}}, head_diff};

    rot_d.rel_heading = head_diff_ext[HEAD_W-1:0];
    if (fold) begin
      rot_d.x = '0 - x_scaled;
      rot_d.y = '0 - y_scaled;
      rot_d.z = {{2{~zu[TURN_W-1]}}, ~zu[TURN_W-1], zu[TURN_W-2:0]};
    end else begin
      rot_d.x = x_scaled;
      rot_d.y = y_scaled;
      rot_d.z = {{2{zu[TURN_W-1]}}, zu};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

[hw/rtl/w2o_cordic.sv]
// ----------------------------------------------------------------------------
// World to object frame: CORDIC rotator
// Rotation-mode CORDIC with one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module w2o_cordic
  import w2o_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  w2o_rot_t rot_i,
  output logic     valid_o,
  output w2o_rot_t rot_o
);

  w2o_rot_t stage_in [CORDIC_N];
  w2o_rot_t stage_d  [CORDIC_N];
  w2o_rot_t stage_q  [CORDIC_N];
  logic     vin      [CORDIC_N];
  logic     valid_q  [CORDIC_N];

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stage_in[i] = rot_i;
      assign vin[i]      = valid_i;
    end else begin : g_next
      assign stage_in[i] = stage_q[i-1];
      assign vin[i]      = valid_q[i-1];
    end

    always_comb begin
      logic signed [VEC_W-1:0] xs;
      logic signed [VEC_W-1:0] ys;
      logic signed [Z_W-1:0]   step;
      xs   = stage_in[i].x >>> i;
      ys   = stage_in[i].y >>> i;
      step = $signed({{(Z_W - TURN_W){1'b0}}, ATAN_TURN[i]});
      stage_d[i].rel_heading = stage_in[i].rel_heading;
      if (!stage_in[i].z[Z_W-1]) begin
        stage_d[i].x = stage_in[i].x - ys;
        stage_d[i].y = stage_in[i].y + xs;
        stage_d[i].z = stage_in[i].z - step;
      end else begin
        stage_d[i].x = stage_in[i].x + ys;
        stage_d[i].y = stage_in[i].y - xs;
        stage_d[i].z = stage_in[i].z + step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= vin[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  assign valid_o = valid_q[CORDIC_N-1];
  assign rot_o   = stage_q[CORDIC_N-1];

endmodule

[hw/rtl/w2o_gain.sv]
// ----------------------------------------------------------------------------
// World to object frame: gain correction and output register
// Scales by the inverse CORDIC gain, rounds, saturates and holds the result.
// ----------------------------------------------------------------------------
`include "world_to_object_frame_defines.svh"

module w2o_gain
  import w2o_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  w2o_rot_t rot_i,
  output logic     valid_o,
  output w2o_res_t res_o
);

  logic signed [PROD_W-1:0] prod_x_d;
  logic signed [PROD_W-1:0] prod_y_d;
  logic signed [PROD_W-1:0] prod_x_q;
  logic signed [PROD_W-1:0] prod_y_q;
  logic [HEAD_W-1:0]        head_q;
  logic                     prod_valid_q;

  logic signed [PROD_W-1:0] rx;
  logic signed [PROD_W-1:0] ry;
  logic signed [PROD_W-1:0] cx;
  logic signed [PROD_W-1:0] cy;
  logic                     sat_x;
  logic                     sat_y;
  w2o_res_t                 res_d;
  w2o_res_t                 res_q;
  logic                     res_valid_q;

  assign prod_x_d = PROD_W'(rot_i.x) * PROD_W'(KINV);
  assign prod_y_d = PROD_W'(rot_i.y) * PROD_W'(KINV);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      head_q   <= rot_i.rel_heading;
    end
  end

  always_comb begin
    rx    = (prod_x_q + ROUND_HALF) >>> ROUND_SHIFT;
    ry    = (prod_y_q + ROUND_HALF) >>> ROUND_SHIFT;
    sat_x = (rx > SAT_HI) || (rx < SAT_LO);
    sat_y = (ry > SAT_HI) || (ry < SAT_LO);
    cx    = (rx > SAT_HI) ? SAT_HI : ((rx < SAT_LO) ? SAT_LO : rx);
    cy    = (ry > SAT_HI) ? SAT_HI : ((ry < SAT_LO) ? SAT_LO : ry);
    res_d.local_x          = cx[OUT_W-1:0];
    res_d.local_y          = cy[OUT_W-1:0];
    res_d.relative_heading = head_q;
    res_d.saturated        = sat_x | sat_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= valid_i;
      res_valid_q  <= prod_valid_q;
    end
  end

  assign valid_o = res_valid_q;
  assign res_o   = res_q;

  `W2O_ASSERT(a_sat_at_limit, (res_valid_q && res_q.saturated) |-> ((res_q.local_x == SAT_HI[OUT_W-1:0]) || (res_q.local_x == SAT_LO[OUT_W-1:0]) || (res_q.local_y == SAT_HI[OUT_W-1:0]) || (res_q.local_y == SAT_LO[OUT_W-1:0])), "saturated flag set without a clipped coordinate")
  `W2O_ASSERT(a_advance, (en_i && prod_valid_q) |=> res_valid_q, "product stage request lost on advance")
  `W2O_ASSERT(a_hold, (!en_i) |=> ($stable(res_valid_q) && $stable(prod_valid_q)), "pipeline valid changed during stall")
  `W2O_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=> (!res_valid_q && !prod_valid_q), "valid set during reset")

endmodule

[sim/frame_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World to object frame: result checker
// Watches both stream channels of the frame transform. For every accepted
// request it computes the local coordinates, the saturation flag and the
// relative heading with its own bit-exact CORDIC, queues them, and compares
// every accepted result against the oldest queued expectation.
// ----------------------------------------------------------------------------
module frame_result_checker
  import w2o_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         req_ready_i,
  input  logic [159:0] req_data_i,
  input  logic         res_valid_i,
  input  logic         res_ready_i,
  input  logic [79:0]  res_data_i,
  input  logic         res_sat_i,
  output int           pending_o,
  output int           fail_count_o
);

  localparam longint GUARD_SCALE = 256;
  localparam longint GAIN_INV    = 636751;
  localparam int     GAIN_SHIFT  = 28;
  localparam int     REPORT_MAX  = 10;

  logic [31:0] atan_step [32];
  w2o_res_t    expected_frames [$];
  int          failures;

  initial begin
    atan_step = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };
    failures = 0;
  end

  function automatic longint scale_and_clip(input longint v, inout logic clipped);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    r  = (v * GAIN_INV + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
    if (r > hi) begin
      clipped = 1'b1;
      r = hi;
    end else if (r < lo) begin
      clipped = 1'b1;
      r = lo;
    end
    return r;
  endfunction

  function automatic w2o_res_t object_frame(input logic [159:0] d);
    longint                       x;
    longint                       y;
    longint                       xs;
    longint                       ys;
    longint                       z;
    longint                       lx;
    longint                       ly;
    logic [15:0]                  ph;
    logic [15:0]                  oh;
    logic [ANGLE_BITS-1:0]        ang;
    logic signed [ANGLE_BITS-1:0] rel;
    logic [31:0]                  zu;
    logic                         clipped;
    int                           i;
    w2o_res_t                     r;
    ph = d[79:64];
    oh = d[159:144];
    x  = (longint'($signed(d[31:0])) - longint'($signed(d[111:80]))) * GUARD_SCALE;
    y  = (longint'($signed(d[63:32])) - longint'($signed(d[143:112]))) * GUARD_SCALE;
    ang = ANGLE_BITS'(longint'($signed(oh)));
    zu  = 32'd0 - (32'(ang) << (32 - ANGLE_BITS));
    if (zu[31:30] == 2'b01 || zu[31:30] == 2'b10) begin
      x  = -x;
      y  = -y;
      zu = zu + 32'h8000_0000;
    end
    z = longint'($signed(zu));
    for (i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_step[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_step[i]);
      end
    end
    clipped = 1'b0;
    lx  = scale_and_clip(x, clipped);
    ly  = scale_and_clip(y, clipped);
    rel = ph - oh;
    r.local_x          = lx[31:0];
    r.local_y          = ly[31:0];
    r.relative_heading = 16'(rel);
    r.saturated        = clipped;
    return r;
  endfunction

  always @(posedge clk_i) begin
    w2o_res_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        expected_frames.push_back(object_frame(req_data_i));
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_frames.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("error: result with no pending request, x=%0d y=%0d h=%0d s=%0b",
                     $signed(res_data_i[31:0]), $signed(res_data_i[63:32]),
                     $signed(res_data_i[79:64]), res_sat_i);
          end
        end else begin
          want = expected_frames.pop_front();
          if (res_data_i[31:0] !== want.local_x || res_data_i[63:32] !== want.local_y ||
              res_data_i[79:64] !== want.relative_heading ||
              res_sat_i !== want.saturated) begin
            failures++;
            if (failures <= REPORT_MAX) begin
              $display("error: expected x=%0d y=%0d h=%0d s=%0b, got x=%0d y=%0d h=%0d s=%0b",
                       $signed(want.local_x), $signed(want.local_y),
                       $signed(want.relative_heading), want.saturated,
                       $signed(res_data_i[31:0]), $signed(res_data_i[63:32]),
                       $signed(res_data_i[79:64]), res_sat_i);
            end
          end
        end
      end
    end
    pending_o    <= expected_frames.size();
    fail_count_o <= failures;
  end

endmodule

[sim/tb_world_to_object_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World to object frame: testbench
// Sends directed poses (coincident points, extreme coordinates, quadrant
// boundaries of the object heading, heading wrap) and then random poses,
// some of them points near or on their object, with random gaps on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_world_to_object_frame;
  import w2o_pkg::*;

  localparam int RANDOM_POSES = 900;
  localparam int LATENCY      = CORDIC_STAGES + 3;
  localparam int STALL_LIMIT  = 2000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           pending;
  int           fail_count;
  logic         steady = 1'b0;
  int           stall_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  world_to_object_frame u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  frame_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_sat_i    (m_axis_tuser),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
        $display("** world_to_object_frame: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_pose(input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] ph, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [15:0] oh);
    while (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {oh, oy, ox, ph, py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] sweep [8];
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] r;
    logic [15:0] oh;
    int          n;
    int          kind;

    sweep = '{16'h4000, 16'h4001, 16'h3fff, 16'hc000, 16'hbfff, 16'h8000,
              16'h7fff, 16'h8001};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(32'd0, 32'd0, 16'd0, 32'd0, 32'd0, 16'd0);
    send_pose(32'h1234_5678, 32'hfedc_ba98, 16'h4000, 32'h1234_5678, 32'hfedc_ba98,
              16'h2222);
    send_pose(32'h8000_0000, 32'h7fff_ffff, 16'h8000, 32'h8000_0000, 32'h7fff_ffff,
              16'h7fff);
    send_pose(32'd1, 32'd0, 16'd0, 32'd0, 32'd0, 16'd0);
    send_pose(32'hffff_ffff, 32'd1, 16'd0, 32'd0, 32'd0, 16'h4000);
    send_pose(32'h7fff_ffff, 32'd0, 16'd0, 32'h8000_0000, 32'd0, 16'd0);
    send_pose(32'h8000_0000, 32'h8000_0000, 16'd0, 32'h7fff_ffff, 32'h7fff_ffff,
              16'h2000);
    send_pose(32'h7fff_ffff, 32'h7fff_ffff, 16'd0, 32'd0, 32'd0, 16'h2000);
    for (n = 0; n < 8; n++) begin
      send_pose(32'd1000000, -32'sd250000, 16'h1111, 32'd0, 32'd0, sweep[n]);
    end
    send_pose(32'd5000, 32'd7000, 16'h8000, 32'd0, 32'd0, 16'h7fff);
    send_pose(32'd5000, 32'd7000, 16'h7fff, 32'd0, 32'd0, 16'h8000);
    send_pose(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff);

    for (n = 0; n < RANDOM_POSES; n++) begin
      steady = (n >= 350 && n < 550);
      if (n == 600) begin
        wait_drained();
      end
      kind = $urandom_range(9);
      ox   = $urandom;
      oy   = $urandom;
      r    = $urandom;
      if (kind < 4) begin
        px = $urandom;
        py = $urandom;
      end else if (kind < 7) begin
        px = ox + {{12{r[19]}}, r[19:0]};
        r  = $urandom;
        py = oy + {{12{r[19]}}, r[19:0]};
      end else if (kind == 7) begin
        px = ox;
        py = oy;
      end else begin
        px = ox + {{2{r[29]}}, r[29:0]};
        r  = $urandom;
        py = oy + {{2{r[29]}}, r[29:0]};
      end
      if ($urandom_range(3) == 0) begin
        oh = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(2)) - 16'd1;
      end else begin
        oh = $urandom;
      end
      send_pose(px, py, 16'($urandom), ox, oy, oh);
    end
    steady = 1'b0;

    wait_drained();
    repeat (2 * LATENCY + 2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** world_to_object_frame: PASSED **");
    end else begin
      $display("** world_to_object_frame: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/w2o_pkg.sv
hw/rtl/w2o_prep.sv
hw/rtl/w2o_cordic.sv
hw/rtl/w2o_gain.sv
hw/rtl/world_to_object_frame.sv
sim/frame_result_checker.sv
sim/tb_world_to_object_frame.sv
